@@ hw/rtl/oawt_pkg.sv @@
// ----------------------------------------------------------------------------
// oawt_pkg: shared types, codes and character tables of the tokenizer
// Holds the token kinds, the one-hot lexer modes, the result record and
// the small character classification functions used by the lexer core.
// ----------------------------------------------------------------------------
`default_nettype none

package oawt_pkg;

    // Default width of the kept line number
    localparam int LINE_NUMBER_BITS_DEF = 16;
    // Width of the line fields on the ports
    localparam int LINE_FIELD_BITS = 16;
    localparam int KIND_BITS = 6;
    // Result slots per character; one character causes at most two results
    localparam int MAX_RESULTS = 3;

    typedef logic [KIND_BITS-1:0] kind_t;

    // Token kinds with a role of their own in the lexer
    localparam kind_t K_FN        = 6'd0;
    localparam kind_t K_POW_EQ    = 6'd29;
    localparam kind_t K_POW       = 6'd30;
    localparam kind_t K_FLOAT     = 6'd46;
    localparam kind_t K_INT       = 6'd47;
    localparam kind_t K_IDENT     = 6'd48;
    // Internal markers, never sent
    localparam kind_t K_STAR_PAIR = 6'd62;
    localparam kind_t K_NONE      = 6'd63;

    // Characters the lexer looks at by name
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    // Pending-token mode of the lexer
    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_OP     = 6'b000010,
        MODE_STAR2  = 6'b000100,
        MODE_F      = 6'b001000,
        MODE_IDENT  = 6'b010000,
        MODE_NUMBER = 6'b100000
    } mode_t;

    // One result record
    typedef struct packed {
        kind_t                      kind;
        logic                       has_text;
        logic [7:0]                 text_char;
        logic                       text_last;
        logic [LINE_FIELD_BITS-1:0] line;
    } token_t;

    // Single punctuation that is a token on its own
    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h28:   k = 6'd1;   // (
            8'h29:   k = 6'd2;   // )
            8'h5B:   k = 6'd3;   // [
            8'h5D:   k = 6'd4;   // ]
            8'h7B:   k = 6'd5;   // {
            8'h7D:   k = 6'd6;   // }
            8'h3A:   k = 6'd7;   // :
            8'h3B:   k = 6'd8;   // ;
            8'h2C:   k = 6'd9;   // ,
            8'h3E:   k = 6'd10;  // >
            8'h3C:   k = 6'd11;  // <
            8'h40:   k = 6'd12;  // @
            8'h24:   k = 6'd13;  // $
            8'h22:   k = 6'd14;  // "
            8'h27:   k = 6'd15;  // '
            8'h3F:   k = 6'd16;  // ?
            8'h2E:   k = 6'd17;  // .
            8'h23:   k = 6'd18;  // #
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Operator start characters, as a token on their own
    function automatic kind_t op_single(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h21:   k = 6'd20;  // !
            8'h2D:   k = 6'd23;  // -
            8'h2B:   k = 6'd25;  // +
            8'h2F:   k = 6'd27;  // /
            8'h2A:   k = 6'd31;  // *
            8'h25:   k = 6'd33;  // %
            8'h26:   k = 6'd36;  // &
            8'h7C:   k = 6'd39;  // |
            8'h7E:   k = 6'd41;  // ~
            8'h5E:   k = 6'd43;  // ^
            8'h3D:   k = 6'd45;  // =
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Two-character operators; a star pair is marked for a third look
    function automatic kind_t op_pair(input logic [7:0] h, input logic [7:0] c);
        kind_t k;
        k = K_NONE;
        if (c == CH_EQ) begin
            case (h)
                8'h21:   k = 6'd19;
                8'h2D:   k = 6'd22;
                8'h2B:   k = 6'd24;
                8'h2F:   k = 6'd26;
                8'h2A:   k = 6'd28;
                8'h25:   k = 6'd32;
                8'h26:   k = 6'd34;
                8'h7C:   k = 6'd37;
                8'h7E:   k = 6'd40;
                8'h5E:   k = 6'd42;
                8'h3D:   k = 6'd44;
                default: k = K_NONE;
            endcase
        end else if (h == CH_MINUS && c == CH_GT) begin
            k = 6'd21;
        end else if (h == CH_STAR && c == CH_STAR) begin
            k = K_STAR_PAIR;
        end else if (h == CH_AMP && c == CH_AMP) begin
            k = 6'd35;
        end else if (h == CH_PIPE && c == CH_PIPE) begin
            k = 6'd38;
        end
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A))
            || ((c >= 8'h41) && (c <= 8'h5A)) || (c == CH_USCORE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/oawt_core.sv @@
// ----------------------------------------------------------------------------
// oawt_core: longest-match lexer state and per-character decision
// Holds the pending token and, for each accepted character, produces up to
// two result records with short combinational case logic.
// ----------------------------------------------------------------------------
`default_nettype none

module oawt_core #(
    parameter int LINE_NUMBER_BITS = oawt_pkg::LINE_NUMBER_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 accept,
    input  wire logic [7:0]                           character,
    input  wire logic [oawt_pkg::LINE_FIELD_BITS-1:0] line_number,
    input  wire logic                                 end_of_line,
    output oawt_pkg::token_t                          results [oawt_pkg::MAX_RESULTS],
    output logic [1:0]                                result_count
);

    // Kept line bits never exceed the port field
    localparam int LW = (LINE_NUMBER_BITS < oawt_pkg::LINE_FIELD_BITS)
                        ? LINE_NUMBER_BITS : oawt_pkg::LINE_FIELD_BITS;

    typedef struct packed {
        logic            emit;
        oawt_pkg::kind_t kind;
        logic            hold;
        oawt_pkg::mode_t mode;
    } fresh_t;

    oawt_pkg::mode_t mode_reg, mode_next;
    logic [7:0]      held_char_reg, held_char_next;
    logic            seen_point_reg, seen_point_next;
    logic [LW-1:0]   held_line_reg, held_line_next;

    // Decide what a character does when nothing is pending
    function automatic fresh_t start_fresh(input logic [7:0] c);
        fresh_t f;
        oawt_pkg::kind_t pk;
        pk = oawt_pkg::punct_kind(c);
        f.emit = 1'b0;
        f.kind = pk;
        f.hold = 1'b0;
        f.mode = oawt_pkg::MODE_IDLE;
        if (c == oawt_pkg::CH_F) begin
            f.hold = 1'b1;
            f.mode = oawt_pkg::MODE_F;
        end else if (pk != oawt_pkg::K_NONE) begin
            f.emit = 1'b1;
        end else if (oawt_pkg::op_single(c) != oawt_pkg::K_NONE) begin
            f.hold = 1'b1;
            f.mode = oawt_pkg::MODE_OP;
        end else if (oawt_pkg::is_space(c)) begin
            f.hold = 1'b0;
        end else if (oawt_pkg::is_digit(c)) begin
            f.hold = 1'b1;
            f.mode = oawt_pkg::MODE_NUMBER;
        end else begin
            f.hold = 1'b1;
            f.mode = oawt_pkg::MODE_IDENT;
        end
        return f;
    endfunction

    function automatic oawt_pkg::token_t mk_tok(
        input oawt_pkg::kind_t kind,
        input logic            has,
        input logic [7:0]      ch,
        input logic            last,
        input logic [LW-1:0]   line
    );
        oawt_pkg::token_t t;
        t.kind      = kind;
        t.has_text  = has;
        t.text_char = ch;
        t.text_last = last;
        t.line      = oawt_pkg::LINE_FIELD_BITS'(line);
        return t;
    endfunction

    // Decide results and next state for the offered character
    always_comb
    begin
        logic [LW-1:0]   line_in;
        oawt_pkg::kind_t pk;
        fresh_t          f;
        logic            do_fresh;
        logic [1:0]      n;

        line_in         = line_number[LW-1:0];
        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        seen_point_next = seen_point_reg;
        held_line_next  = held_line_reg;
        do_fresh        = 1'b0;
        n               = 2'd0;
        f               = start_fresh(character);
        pk              = oawt_pkg::op_pair(held_char_reg, character);
        for (int i = 0; i < oawt_pkg::MAX_RESULTS; i++) begin
            results[i] = mk_tok(oawt_pkg::K_NONE, 1'b0, 8'd0, 1'b1, held_line_reg);
        end

        // First phase: settle the pending token against this character
        case (mode_reg)
            oawt_pkg::MODE_OP:
            begin
                if (pk == oawt_pkg::K_STAR_PAIR) begin
                    mode_next = oawt_pkg::MODE_STAR2;
                end else if (pk != oawt_pkg::K_NONE) begin
                    results[n] = mk_tok(pk, 1'b0, 8'd0, 1'b1, held_line_reg);
                    n = n + 2'd1;
                    mode_next = oawt_pkg::MODE_IDLE;
                end else begin
                    results[n] = mk_tok(oawt_pkg::op_single(held_char_reg), 1'b0, 8'd0,
                                        1'b1, held_line_reg);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            oawt_pkg::MODE_STAR2:
            begin
                if (character == oawt_pkg::CH_EQ) begin
                    results[n] = mk_tok(oawt_pkg::K_POW_EQ, 1'b0, 8'd0, 1'b1, held_line_reg);
                    n = n + 2'd1;
                    mode_next = oawt_pkg::MODE_IDLE;
                end else begin
                    results[n] = mk_tok(oawt_pkg::K_POW, 1'b0, 8'd0, 1'b1, held_line_reg);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            oawt_pkg::MODE_F, oawt_pkg::MODE_IDENT:
            begin
                if (mode_reg == oawt_pkg::MODE_F && character == oawt_pkg::CH_N) begin
                    results[n] = mk_tok(oawt_pkg::K_FN, 1'b0, 8'd0, 1'b1, held_line_reg);
                    n = n + 2'd1;
                    mode_next = oawt_pkg::MODE_IDLE;
                end else if (oawt_pkg::is_word(character)) begin
                    // Send the held character, keep the new one
                    results[n] = mk_tok(oawt_pkg::K_IDENT, 1'b1, held_char_reg, 1'b0,
                                        held_line_reg);
                    n = n + 2'd1;
                    mode_next = oawt_pkg::MODE_IDENT;
                    held_char_next = character;
                end else begin
                    results[n] = mk_tok(oawt_pkg::K_IDENT, 1'b1, held_char_reg, 1'b1,
                                        held_line_reg);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            oawt_pkg::MODE_NUMBER:
            begin
                if (oawt_pkg::is_digit(character)
                    || (character == oawt_pkg::CH_POINT && !seen_point_reg)) begin
                    if (character == oawt_pkg::CH_POINT) begin
                        seen_point_next = 1'b1;
                    end
                    results[n] = mk_tok(seen_point_next ? oawt_pkg::K_FLOAT : oawt_pkg::K_INT,
                                        1'b1, held_char_reg, 1'b0, held_line_reg);
                    n = n + 2'd1;
                    held_char_next = character;
                end else begin
                    results[n] = mk_tok(seen_point_reg ? oawt_pkg::K_FLOAT : oawt_pkg::K_INT,
                                        1'b1, held_char_reg, 1'b1, held_line_reg);
                    n = n + 2'd1;
                    do_fresh = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // Return to idle and let the character start a new token
        if (mode_next == oawt_pkg::MODE_IDLE || do_fresh) begin
            mode_next       = oawt_pkg::MODE_IDLE;
            held_char_next  = 8'd0;
            seen_point_next = 1'b0;
        end
        if (do_fresh) begin
            if (f.emit) begin
                results[n] = mk_tok(f.kind, 1'b0, 8'd0, 1'b1, line_in);
                n = n + 2'd1;
            end
            if (f.hold) begin
                mode_next       = f.mode;
                held_char_next  = character;
                held_line_next  = line_in;
                seen_point_next = 1'b0;
            end
        end

        // Second phase: flush the pending token at the end of a line
        if (end_of_line) begin
            case (mode_next)
                oawt_pkg::MODE_OP:
                begin
                    results[n] = mk_tok(oawt_pkg::op_single(held_char_next), 1'b0, 8'd0,
                                        1'b1, held_line_next);
                    n = n + 2'd1;
                end
                oawt_pkg::MODE_STAR2:
                begin
                    results[n] = mk_tok(oawt_pkg::K_POW, 1'b0, 8'd0, 1'b1, held_line_next);
                    n = n + 2'd1;
                end
                oawt_pkg::MODE_F, oawt_pkg::MODE_IDENT:
                begin
                    results[n] = mk_tok(oawt_pkg::K_IDENT, 1'b1, held_char_next, 1'b1,
                                        held_line_next);
                    n = n + 2'd1;
                end
                oawt_pkg::MODE_NUMBER:
                begin
                    results[n] = mk_tok(seen_point_next ? oawt_pkg::K_FLOAT : oawt_pkg::K_INT,
                                        1'b1, held_char_next, 1'b1, held_line_next);
                    n = n + 2'd1;
                end
                default:
                begin
                    n = n;
                end
            endcase
            mode_next       = oawt_pkg::MODE_IDLE;
            held_char_next  = 8'd0;
            seen_point_next = 1'b0;
        end

        result_count = accept ? n : 2'd0;
    end

    // Advance the pending token on each accepted character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= oawt_pkg::MODE_IDLE;
            held_char_reg  <= 8'd0;
            seen_point_reg <= 1'b0;
            held_line_reg  <= '0;
        end else if (accept) begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            seen_point_reg <= seen_point_next;
            held_line_reg  <= held_line_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/oawt_queue.sv @@
// ----------------------------------------------------------------------------
// oawt_queue: four-entry result queue
// Takes up to three result records in a cycle and hands out one per
// transaction; reports room while a whole character's results still fit.
// ----------------------------------------------------------------------------
`default_nettype none

module oawt_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire oawt_pkg::token_t push_data [oawt_pkg::MAX_RESULTS],
    input  wire logic [1:0]       push_count,
    input  wire logic             pop,
    output logic                  room,
    output logic                  out_valid,
    output oawt_pkg::token_t      out_data
);

    localparam int DEPTH = 4;

    oawt_pkg::token_t entries [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       do_pop;

    // Room for three more records, counting only what is stored now
    assign room      = (count_reg <= 3'd1);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = entries[rd_ptr_reg];
    assign do_pop    = pop && out_valid;

    assign wr_ptr_next = wr_ptr_reg + push_count;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, do_pop};
    assign count_next  = count_reg + {1'b0, push_count} - {2'b00, do_pop};

    // Write the new records behind the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < oawt_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < push_count) begin
                entries[wr_ptr_reg + 2'(i)] <= push_data[i];
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/operator_and_word_tokenizer.sv @@
// ----------------------------------------------------------------------------
// operator_and_word_tokenizer: longest-match tokenizer, one byte per input
// Usage:
//   The slave stream carries one source byte per transaction with its line
//   number; tlast marks the last byte of a line and flushes a pending token.
//   The master stream carries one result per transaction: token kind, text
//   byte and the start line in tdata, a text flag in tuser, and tlast on the
//   last text byte or on any token without text.
//   A byte is decided in the cycle it is accepted; its results are written
//   into a four-entry result queue, which parts the two sides and hands
//   them to the master side one result per transaction.
//   Throughput is one byte per cycle as long as each byte yields at most one
//   result and the receiver does not stall; a byte that yields two results
//   occupies the master side for one transaction per result.
//   s_axis_tready stays high while the queue holds at most one result.
//   When the receiver stalls, results wait in the queue and tready drops
//   once more than one is stored; nothing is lost.
//   Reset clears the pending token and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module operator_and_word_tokenizer #(
    parameter int LINE_NUMBER_BITS = oawt_pkg::LINE_NUMBER_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // character[7:0], line_number[23:8]
    input  wire logic        s_axis_tlast,   // end_of_line
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // token_kind[5:0], text_char[13:6],
                                             // token_line[29:14], zero[31:30]
    output logic             m_axis_tuser,   // has_text
    output logic             m_axis_tlast    // text_last
);

    logic             in_accept;
    oawt_pkg::token_t results [oawt_pkg::MAX_RESULTS];
    logic [1:0]       result_count;
    logic             room;
    oawt_pkg::token_t head;

    assign s_axis_tready = room;
    assign in_accept     = s_axis_tvalid && room;

    // Decide results for each accepted byte
    oawt_core #(
        .LINE_NUMBER_BITS(LINE_NUMBER_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .character    (s_axis_tdata[7:0]),
        .line_number  (s_axis_tdata[23:8]),
        .end_of_line  (s_axis_tlast),
        .results      (results),
        .result_count (result_count)
    );

    // Hold results until the receiver takes them
    oawt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (results),
        .push_count (result_count),
        .pop        (m_axis_tready),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_data   (head)
    );

    // Pack the head record
    assign m_axis_tdata = {2'b00, head.line, head.text_char, head.kind};
    assign m_axis_tuser = head.has_text;
    assign m_axis_tlast = head.text_last;

endmodule

`default_nettype wire

@@ bench/operator_and_word_tokenizer_checker.sv @@
// ----------------------------------------------------------------------------
// operator_and_word_tokenizer_checker: result checker of the tokenizer bench
// Watches both streams of the tokenizer. Every accepted source byte is run
// through a longest-match predictor, and the tokens it yields are queued.
// Every accepted result is compared field by field with the oldest queued
// token. The failure count and the number of tokens still due go to the top.
// ----------------------------------------------------------------------------
module operator_and_word_tokenizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [23:0] s_data,     // character[7:0], line_number[23:8]
    input  logic        s_last,     // end_of_line
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_data,     // token_kind[5:0], text_char[13:6],
                                    // token_line[29:14], zero[31:30]
    input  logic        m_user,     // has_text
    input  logic        m_last,     // text_last
    output int          errors,
    output int          tokens_due
);

    // Token kinds, dense in the order the lexer defines them
    typedef enum logic [5:0] {
        TK_FN, TK_LPAREN, TK_RPAREN, TK_LBRACK, TK_RBRACK, TK_LBRACE, TK_RBRACE,
        TK_COLON, TK_SEMI, TK_COMMA, TK_GT, TK_LT, TK_AT, TK_DOLLAR, TK_DQUOTE,
        TK_SQUOTE, TK_QUEST, TK_POINT, TK_HASH, TK_NE, TK_BANG, TK_ARROW,
        TK_SUB_EQ, TK_MINUS, TK_ADD_EQ, TK_PLUS, TK_DIV_EQ, TK_SLASH, TK_MUL_EQ,
        TK_POW_EQ, TK_POW, TK_STAR, TK_MOD_EQ, TK_PERCENT, TK_AND_EQ, TK_AND_AND,
        TK_AMP, TK_OR_EQ, TK_OR_OR, TK_PIPE, TK_TILDE_EQ, TK_TILDE, TK_XOR_EQ,
        TK_CARET, TK_EQ_EQ, TK_ASSIGN, TK_FLOAT, TK_INT, TK_IDENT,
        TK_NONE = 6'd63
    } tok_kind_e;

    // Predictor state
    oawt_pkg::mode_t lex_mode;
    logic [7:0]      lex_held;
    logic            lex_point;
    logic [15:0]     lex_tok_line;

    oawt_pkg::token_t expected_tokens[$];

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return digit_char(c) || ((c >= "a") && (c <= "z"))
            || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic space_char(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic tok_kind_e lone_punct(input logic [7:0] c);
        tok_kind_e k;
        case (c)
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            "[":     k = TK_LBRACK;
            "]":     k = TK_RBRACK;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            ":":     k = TK_COLON;
            ";":     k = TK_SEMI;
            ",":     k = TK_COMMA;
            ">":     k = TK_GT;
            "<":     k = TK_LT;
            "@":     k = TK_AT;
            "$":     k = TK_DOLLAR;
            "\"":    k = TK_DQUOTE;
            "'":     k = TK_SQUOTE;
            "?":     k = TK_QUEST;
            ".":     k = TK_POINT;
            "#":     k = TK_HASH;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    function automatic tok_kind_e lone_op(input logic [7:0] c);
        tok_kind_e k;
        case (c)
            "!":     k = TK_BANG;
            "-":     k = TK_MINUS;
            "+":     k = TK_PLUS;
            "/":     k = TK_SLASH;
            "*":     k = TK_STAR;
            "%":     k = TK_PERCENT;
            "&":     k = TK_AMP;
            "|":     k = TK_PIPE;
            "~":     k = TK_TILDE;
            "^":     k = TK_CARET;
            "=":     k = TK_ASSIGN;
            default: k = TK_NONE;
        endcase
        return k;
    endfunction

    // Two-byte operators; the star pair is left to the caller
    function automatic tok_kind_e op_combo(input logic [7:0] h, input logic [7:0] c);
        tok_kind_e k;
        k = TK_NONE;
        if (c == "=") begin
            case (h)
                "!":     k = TK_NE;
                "-":     k = TK_SUB_EQ;
                "+":     k = TK_ADD_EQ;
                "/":     k = TK_DIV_EQ;
                "*":     k = TK_MUL_EQ;
                "%":     k = TK_MOD_EQ;
                "&":     k = TK_AND_EQ;
                "|":     k = TK_OR_EQ;
                "~":     k = TK_TILDE_EQ;
                "^":     k = TK_XOR_EQ;
                "=":     k = TK_EQ_EQ;
                default: k = TK_NONE;
            endcase
        end else if (h == "-" && c == ">") begin
            k = TK_ARROW;
        end else if (h == "&" && c == "&") begin
            k = TK_AND_AND;
        end else if (h == "|" && c == "|") begin
            k = TK_OR_OR;
        end
        return k;
    endfunction

    task automatic emit_token(input tok_kind_e k, input logic has, input logic [7:0] ch,
                              input logic last, input logic [15:0] ln);
        oawt_pkg::token_t t;
        t.kind      = k;
        t.has_text  = has;
        t.text_char = ch;
        t.text_last = last;
        t.line      = ln;
        expected_tokens.push_back(t);
    endtask

    task automatic go_idle();
        lex_mode  = oawt_pkg::MODE_IDLE;
        lex_held  = 8'd0;
        lex_point = 1'b0;
    endtask

    task automatic hold_char(input oawt_pkg::mode_t m, input logic [7:0] c,
                             input logic [15:0] ln);
        lex_mode     = m;
        lex_held     = c;
        lex_tok_line = ln;
        lex_point    = 1'b0;
    endtask

    // Open a token from idle
    task automatic begin_token(input logic [7:0] c, input logic [15:0] ln);
        if (c == "f")
            hold_char(oawt_pkg::MODE_F, c, ln);
        else if (lone_punct(c) != TK_NONE)
            emit_token(lone_punct(c), 1'b0, 8'd0, 1'b1, ln);
        else if (lone_op(c) != TK_NONE)
            hold_char(oawt_pkg::MODE_OP, c, ln);
        else if (space_char(c))
            ;
        else if (digit_char(c))
            hold_char(oawt_pkg::MODE_NUMBER, c, ln);
        else
            hold_char(oawt_pkg::MODE_IDENT, c, ln);
    endtask

    // Advance the predictor by one source byte
    task automatic tokenize_char(input logic [7:0] c, input logic [15:0] ln, input logic eol);
        tok_kind_e k;
        tok_kind_e num_k;
        num_k = lex_point ? TK_FLOAT : TK_INT;
        case (lex_mode)
            oawt_pkg::MODE_OP: begin
                k = op_combo(lex_held, c);
                if (lex_held == "*" && c == "*") begin
                    lex_mode = oawt_pkg::MODE_STAR2;
                end else if (k != TK_NONE) begin
                    emit_token(k, 1'b0, 8'd0, 1'b1, lex_tok_line);
                    go_idle();
                end else begin
                    emit_token(lone_op(lex_held), 1'b0, 8'd0, 1'b1, lex_tok_line);
                    go_idle();
                    begin_token(c, ln);
                end
            end
            oawt_pkg::MODE_STAR2: begin
                if (c == "=") begin
                    emit_token(TK_POW_EQ, 1'b0, 8'd0, 1'b1, lex_tok_line);
                    go_idle();
                end else begin
                    emit_token(TK_POW, 1'b0, 8'd0, 1'b1, lex_tok_line);
                    go_idle();
                    begin_token(c, ln);
                end
            end
            oawt_pkg::MODE_F, oawt_pkg::MODE_IDENT: begin
                if (lex_mode == oawt_pkg::MODE_F && c == "n") begin
                    emit_token(TK_FN, 1'b0, 8'd0, 1'b1, lex_tok_line);
                    go_idle();
                end else if (word_char(c)) begin
                    lex_mode = oawt_pkg::MODE_IDENT;
                    emit_token(TK_IDENT, 1'b1, lex_held, 1'b0, lex_tok_line);
                    lex_held = c;
                end else begin
                    emit_token(TK_IDENT, 1'b1, lex_held, 1'b1, lex_tok_line);
                    go_idle();
                    begin_token(c, ln);
                end
            end
            oawt_pkg::MODE_NUMBER: begin
                if (digit_char(c) || (c == "." && !lex_point)) begin
                    if (c == ".") begin
                        lex_point = 1'b1;
                        num_k     = TK_FLOAT;
                    end
                    emit_token(num_k, 1'b1, lex_held, 1'b0, lex_tok_line);
                    lex_held = c;
                end else begin
                    emit_token(num_k, 1'b1, lex_held, 1'b1, lex_tok_line);
                    go_idle();
                    begin_token(c, ln);
                end
            end
            default: begin
                go_idle();
                begin_token(c, ln);
            end
        endcase

        // Flush whatever is pending at the end of a line
        if (eol) begin
            num_k = lex_point ? TK_FLOAT : TK_INT;
            case (lex_mode)
                oawt_pkg::MODE_OP:
                    emit_token(lone_op(lex_held), 1'b0, 8'd0, 1'b1, lex_tok_line);
                oawt_pkg::MODE_STAR2:
                    emit_token(TK_POW, 1'b0, 8'd0, 1'b1, lex_tok_line);
                oawt_pkg::MODE_F,
                oawt_pkg::MODE_IDENT:
                    emit_token(TK_IDENT, 1'b1, lex_held, 1'b1, lex_tok_line);
                oawt_pkg::MODE_NUMBER:
                    emit_token(num_k, 1'b1, lex_held, 1'b1, lex_tok_line);
                default: ;
            endcase
            go_idle();
        end
    endtask

    // Print one mismatch line while fewer than 100 are counted, and count it
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 100)
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors = errors + 1;
    endtask

    task automatic check_result();
        oawt_pkg::token_t want;
        if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected result, kind", 32'(m_data[5:0]), 32'd0);
        end else begin
            want = expected_tokens.pop_front();
            if (m_data[5:0] != want.kind)
                report_mismatch("token_kind", 32'(m_data[5:0]), 32'(want.kind));
            if (m_user != want.has_text)
                report_mismatch("has_text", 32'(m_user), 32'(want.has_text));
            if (m_data[13:6] != want.text_char)
                report_mismatch("text_char", 32'(m_data[13:6]), 32'(want.text_char));
            if (m_last != want.text_last)
                report_mismatch("text_last", 32'(m_last), 32'(want.text_last));
            if (m_data[29:14] != want.line)
                report_mismatch("token_line", 32'(m_data[29:14]), 32'(want.line));
            if (m_data[31:30] != 2'b00)
                report_mismatch("tdata padding", 32'(m_data[31:30]), 32'd0);
        end
    endtask

    // Check results first: a byte accepted now shows its results later
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            go_idle();
            lex_tok_line = 16'd0;
            expected_tokens.delete();
            errors     = 0;
            tokens_due = 0;
        end else begin
            if (m_valid && m_ready)
                check_result();
            if (s_valid && s_ready)
                tokenize_char(s_data[7:0], s_data[23:8], s_last);
            tokens_due = expected_tokens.size();
        end
    end

endmodule

@@ bench/operator_and_word_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// operator_and_word_tokenizer_tb: top of the tokenizer bench
// Feeds source bytes: a directed opening with keywords, operator chains,
// numbers with extra points, bytes at both ends of the range and a token
// running over a line change, then random lines built from tokens with
// some noise, under four phases of sender gaps and receiver stalls (the first has neither).
// A checker beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module operator_and_word_tokenizer_tb;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = 24'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int errors;
    int tokens_due;

    // Percent of cycles each side holds off
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Bytes of the random line being built
    logic [7:0] src_q[$];

    always #5 clk = ~clk;

    operator_and_word_tokenizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    operator_and_word_tokenizer_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_data     (s_tdata),
        .s_last     (s_tlast),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_data     (m_tdata),
        .m_user     (m_tuser),
        .m_last     (m_tlast),
        .errors     (errors),
        .tokens_due (tokens_due)
    );

    // Stall the receiver at random
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Send one byte; entered and left at a falling edge
    task automatic send_char(input logic [7:0] c, input logic [15:0] ln, input logic eol);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ln, c};
        s_tlast  <= eol;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_text(input string s, input logic [15:0] ln, input logic eol_at_end);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], ln, eol_at_end && (i == s.len() - 1));
    endtask

    // Hold the sender until every expected token has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (tokens_due != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            src_q.push_back(s[i]);
    endtask

    // Append one random token, or noise, to the line under construction
    task automatic add_piece();
        logic [7:0] c;
        int n;
        case ($urandom_range(0, 11))
            0, 1: begin
                c = pick_from("!-+/*%&|~^=");
                src_q.push_back(c);
                case ($urandom_range(0, 3))
                    0: ;
                    1: src_q.push_back("=");
                    2: begin
                        if (c == "-")      src_q.push_back(">");
                        else if (c == "*") src_q.push_back("*");
                        else if (c == "&") src_q.push_back("&");
                        else if (c == "|") src_q.push_back("|");
                        else               src_q.push_back("=");
                    end
                    default: src_q.push_back(pick_from("=>*&|"));
                endcase
            end
            2: add_text("**=");
            3: src_q.push_back(pick_from("()[]{}:;,><@$\"'?.#"));
            4: add_text("fn");
            5, 6: begin
                if ($urandom_range(0, 7) == 0)
                    src_q.push_back(8'($urandom_range(128, 255)));
                else
                    src_q.push_back(pick_from("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_"));
                n = $urandom_range(0, 4);
                repeat (n)
                    src_q.push_back(pick_from(
                        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_"));
            end
            7, 8: begin
                n = $urandom_range(1, 4);
                repeat (n) src_q.push_back(pick_from("0123456789"));
                if ($urandom_range(0, 1)) begin
                    src_q.push_back(".");
                    n = $urandom_range(0, 3);
                    repeat (n) src_q.push_back(pick_from("0123456789"));
                    if ($urandom_range(0, 4) == 0)
                        add_text(".7");
                end
            end
            9: src_q.push_back(pick_from(" \t\n\013\014\r"));
            10: src_q.push_back(8'($urandom_range(0, 255)));
            default: begin
                src_q.push_back("f");
                src_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // Build and send one random line; return the number of bytes sent
    task automatic send_random_line(output int sent);
        logic [15:0] ln;
        logic        eol_end;
        int          pieces;
        src_q.delete();
        ln      = 16'($urandom_range(0, 65535));
        pieces  = $urandom_range(1, 4);
        eol_end = ($urandom_range(0, 7) != 0);
        repeat (pieces) begin
            add_piece();
            if ($urandom_range(0, 1))
                src_q.push_back(" ");
        end
        foreach (src_q[i])
            send_char(src_q[i], ln,
                      (eol_end && i == src_q.size() - 1) || ($urandom_range(0, 19) == 0));
        sent = src_q.size();
    endtask

    // Stimulus
    initial begin
        int sent;
        int total;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: keyword, f as identifier start, operator chains
        send_text("fn\tfx_9", 16'd0, 1'b1);
        send_text("**=**->", 16'd1, 1'b1);
        // Second point ends the number; the number runs on over a line change
        send_text("1.2.3", 16'd2, 1'b0);
        send_text("4", 16'd3, 1'b1);
        // Bytes at the ends of the range start identifiers
        send_char(8'h00, 16'hFFFF, 1'b0);
        send_char(8'hFF, 16'hFFFF, 1'b1);
        drain();

        // Random lines under each idling phase
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            total = 0;
            while (total < 24) begin
                send_random_line(sent);
                total += sent;
            end
            drain();
        end

        // Let any stray result surface, then give the verdict
        recv_stall_pct = 0;
        repeat (10) @(negedge clk);
        if (errors == 0 && tokens_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Give up on a hung run
    initial begin
        #500000;
        $display("tb: failure");
        $finish;
    end

endmodule
